// File: src/rppa_pkg.sv
// Shared types, sizes and codes of the random pick page allocator.
// No dependencies; the cell, remainder unit, allocator and testbench import this package.
package rppa_pkg;

  localparam int MAX_PAGES = 1024;
  localparam int LOG_DEPTH = 1024;
  localparam int PAGE_BITS = 12;
  localparam int MAX_DUMP  = 64;

  localparam int PAGE_W    = 32 - PAGE_BITS;
  localparam int IDX_W     = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CNT_W     = $clog2(MAX_PAGES + 1);
  localparam int LOG_AW    = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int LOG_CNT_W = $clog2(LOG_DEPTH + 1);
  localparam int DUMP_W    = $clog2(MAX_DUMP + 1);

  localparam logic [31:0] MEM_STOP_RST = 32'd234881024;

  typedef enum logic [1:0] {
    CMD_FREE  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_DUMP  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_ADDR  = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_BAD_DUMP  = 3'd3,
    ST_LIST_FULL = 3'd4,
    ST_LOG_FULL  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CFG_MEM_START = 2'd0,
    CFG_MEM_STOP  = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP,
    CELL_SWAP
  } cell_op_e;

  typedef struct packed {
    cell_op_e           op;
    logic [IDX_W-1:0]   j;
    logic [IDX_W-1:0]   jm1;
  } cell_ctrl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FREE,
    S_ALLOC,
    S_DIV,
    S_SWAP,
    S_POP,
    S_DUMP_CHK,
    S_DUMP_RD,
    S_DUMP_OUT
  } state_e;

endpackage

// File: src/rppa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rppa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/rppa_cell.sv
// One free list cell: holds one page number and trades it with its neighbors.
// Depends on rppa_pkg.
module rppa_cell import rppa_pkg::*; (
  input  logic              clk_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [IDX_W-1:0]  idx_i,
  input  logic [PAGE_W-1:0] left_i,
  input  logic [PAGE_W-1:0] right_i,
  output logic [PAGE_W-1:0] val_o
);

  logic [PAGE_W-1:0] val_q, val_d;

  always_comb begin
    val_d = val_q;
    unique case (ctrl_i.op)
      CELL_PUSH: val_d = left_i;
      CELL_POP:  val_d = right_i;
      CELL_SWAP: begin
        if (idx_i == ctrl_i.j) begin
          val_d = left_i;
        end else if (idx_i == ctrl_i.jm1) begin
          val_d = right_i;
        end
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

// File: src/rppa_div.sv
// Bit-serial restoring remainder unit: 32-bit dividend modulo the free count.
// Depends on rppa_pkg.
module rppa_div import rppa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [31:0]      dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic             done_o,
  output logic [CNT_W-1:0] rem_o
);

  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [4:0]       cnt_q, cnt_d;
  logic [31:0]      dvd_q, dvd_d;
  logic [CNT_W-1:0] dvs_q, dvs_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [CNT_W:0]   trial;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[31]};
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      dvd_d = dividend_i;
      dvs_d = divisor_i;
      rem_d = '0;
    end else if (run_q) begin
      // shift in one dividend bit, subtract when it fits
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = CNT_W'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[CNT_W-1:0];
      end
      dvd_d = {dvd_q[30:0], 1'b0};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// File: src/random_pick_page_allocator_unit.sv
// Random pick page allocator: free list as a chain of cells, log in a RAM.
// Per command: free runs S_FREE; alloc runs S_ALLOC, then, unless the list is empty, S_DIV
// for the 32-step remainder unit (pos = rand_value mod free count), one cell swap per list
// position in S_SWAP, then S_POP; dump: S_DUMP_CHK, then S_DUMP_RD and S_DUMP_OUT per entry.
// One item at a time, results never stall; busy_o is high after accept to the last result.
// Reset clears counts and mem start, sets mem stop to MEM_STOP_RST; cells, log hold garbage.
module random_pick_page_allocator_unit import rppa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] page_addr_i,
  input  logic [31:0] rand_value_i,
  input  logic [10:0] dump_count_i,
  output logic        result_valid_o,
  output logic [2:0]  status_o,
  output logic [31:0] result_addr_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i
);

  state_e state_q, state_d;

  logic [31:0]          addr_q;
  logic [31:0]          rnd_q;
  logic [10:0]          n_q;
  logic [31:0]          mem_start_q, mem_stop_q;
  logic [CNT_W-1:0]     free_cnt_q, free_cnt_d;
  logic [LOG_CNT_W-1:0] log_cnt_q, log_cnt_d;
  logic [IDX_W-1:0]     j_q, j_d;
  logic [DUMP_W-1:0]    k_q, k_d;

  logic        res_valid_q, res_valid_d;
  logic [2:0]  res_status_q, res_status_d;
  logic [31:0] res_addr_q, res_addr_d;
  logic        res_last_q, res_last_d;

  cell_ctrl_t        cell_ctrl;
  logic [PAGE_W-1:0] vals [MAX_PAGES];
  logic [PAGE_W-1:0] push_page;

  logic              div_start, div_done;
  logic [CNT_W-1:0]  div_rem;

  logic              ram_we, ram_re;
  logic [LOG_AW-1:0] ram_waddr, ram_raddr;
  logic [PAGE_W-1:0] ram_rdata;

  logic accept;
  logic free_bad, dump_bad, dump_last;

  assign accept      = start_i && (state_q == S_IDLE);
  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign push_page   = addr_q[31:PAGE_BITS];

  assign free_bad = (addr_q[PAGE_BITS-1:0] != '0) || (addr_q < mem_start_q) ||
                    (addr_q >= mem_stop_q);
  assign dump_bad = (n_q == 11'd0) || (32'(n_q) > 32'(log_cnt_q)) ||
                    (n_q > 11'(MAX_DUMP));
  assign dump_last = (11'(k_q) + 11'd1 == n_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_e'(command_i))
            CMD_FREE:  state_d = S_FREE;
            CMD_ALLOC: state_d = S_ALLOC;
            CMD_DUMP:  state_d = S_DUMP_CHK;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_FREE:     state_d = S_IDLE;
      S_ALLOC:    state_d = (free_cnt_q == '0) ? S_IDLE : S_DIV;
      S_DIV:      state_d = div_done ? S_SWAP : S_DIV;
      S_SWAP:     state_d = (j_q == '0) ? S_POP : S_SWAP;
      S_POP:      state_d = S_IDLE;
      S_DUMP_CHK: state_d = dump_bad ? S_IDLE : S_DUMP_RD;
      S_DUMP_RD:  state_d = S_DUMP_OUT;
      S_DUMP_OUT: state_d = dump_last ? S_IDLE : S_DUMP_RD;
      default:    state_d = S_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    cell_ctrl.op  = CELL_HOLD;
    cell_ctrl.j   = j_q;
    cell_ctrl.jm1 = j_q - IDX_W'(1);
    div_start     = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = log_cnt_q[LOG_AW-1:0];
    ram_raddr     = LOG_AW'(log_cnt_q - LOG_CNT_W'(1) - LOG_CNT_W'(k_q));
    free_cnt_d    = free_cnt_q;
    log_cnt_d     = log_cnt_q;
    j_d           = j_q;
    k_d           = k_q;
    res_valid_d   = 1'b0;
    res_status_d  = ST_OK;
    res_addr_d    = '0;
    res_last_d    = 1'b1;
    unique case (state_q)
      S_FREE: begin
        res_valid_d = 1'b1;
        if (free_bad) begin
          res_status_d = ST_BAD_ADDR;
        end else if (32'(free_cnt_q) >= 32'(MAX_PAGES)) begin
          res_status_d = ST_LIST_FULL;
        end else begin
          cell_ctrl.op = CELL_PUSH;
          free_cnt_d   = free_cnt_q + CNT_W'(1);
        end
      end
      S_ALLOC: begin
        if (free_cnt_q == '0) begin
          res_valid_d  = 1'b1;
          res_status_d = ST_EMPTY;
        end else begin
          div_start = 1'b1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          j_d = div_rem[IDX_W-1:0];
        end
      end
      S_SWAP: begin
        // bubble the picked entry one cell toward the head
        if (j_q != '0) begin
          cell_ctrl.op = CELL_SWAP;
          j_d          = j_q - IDX_W'(1);
        end
      end
      S_POP: begin
        cell_ctrl.op = CELL_POP;
        free_cnt_d   = free_cnt_q - CNT_W'(1);
        res_valid_d  = 1'b1;
        res_addr_d   = {vals[0], {PAGE_BITS{1'b0}}};
        if (32'(log_cnt_q) >= 32'(LOG_DEPTH)) begin
          res_status_d = ST_LOG_FULL;
        end else begin
          ram_we    = 1'b1;
          log_cnt_d = log_cnt_q + LOG_CNT_W'(1);
        end
      end
      S_DUMP_CHK: begin
        k_d = '0;
        if (dump_bad) begin
          res_valid_d  = 1'b1;
          res_status_d = ST_BAD_DUMP;
        end
      end
      S_DUMP_RD: begin
        ram_re = 1'b1;
      end
      S_DUMP_OUT: begin
        res_valid_d = 1'b1;
        res_addr_d  = {ram_rdata, {PAGE_BITS{1'b0}}};
        res_last_d  = dump_last;
        k_d         = k_q + DUMP_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_cnt_q  <= '0;
      log_cnt_q   <= '0;
      res_valid_q <= 1'b0;
      mem_start_q <= '0;
      mem_stop_q  <= MEM_STOP_RST;
    end else begin
      state_q     <= state_d;
      free_cnt_q  <= free_cnt_d;
      log_cnt_q   <= log_cnt_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_MEM_START: mem_start_q <= cfg_wdata_i;
          CFG_MEM_STOP:  mem_stop_q  <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= page_addr_i;
      rnd_q  <= rand_value_i;
      n_q    <= dump_count_i;
    end
    j_q          <= j_d;
    k_q          <= k_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    res_last_q   <= res_last_d;
  end

  for (genvar g = 0; g < MAX_PAGES; g++) begin : g_cell
    logic [PAGE_W-1:0] left, right;
    if (g == 0) begin : g_head
      assign left = push_page;
    end else begin : g_mid
      assign left = vals[g-1];
    end
    if (g == MAX_PAGES - 1) begin : g_tail
      assign right = '0;
    end else begin : g_body
      assign right = vals[g+1];
    end
    rppa_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .idx_i   (IDX_W'(g)),
      .left_i  (left),
      .right_i (right),
      .val_o   (vals[g])
    );
  end

  rppa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rnd_q),
    .divisor_i  (free_cnt_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  rppa_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (LOG_DEPTH)
  ) u_log (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (vals[0]),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign result_valid_o = res_valid_q;
  assign status_o       = res_status_q;
  assign result_addr_o  = res_addr_q;
  assign last_o         = res_last_q;

`ifndef SYNTHESIS
  a_free_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(free_cnt_q) <= 32'(MAX_PAGES))
    else $error("free count above list size");

  a_log_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(log_cnt_q) <= 32'(LOG_DEPTH))
    else $error("log count above log depth");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("remainder finished outside divide state");

  a_mid_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> (state_q == S_DUMP_RD))
    else $error("non-final word outside a dump");

  a_swap_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWAP) |-> (free_cnt_q != '0) && (32'(j_q) < 32'(free_cnt_q)))
    else $error("swap index outside the list");
`endif

endmodule

// File: tb/sv/tb_random_pick_page_allocator_unit.sv
// Testbench for the random pick page allocator: queued commands, config writes and drains,
// with an in-bench free list and allocation log model that predicts every result word.
// Depends on rppa_pkg and random_pick_page_allocator_unit.
module tb_random_pick_page_allocator_unit;
  import rppa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {JOB_CMD, JOB_CFG, JOB_DRAIN} job_kind_e;

  typedef struct {
    job_kind_e   kind;
    cmd_e        cmd;
    logic [31:0] addr;
    logic [31:0] rnd;
    logic [10:0] n;
    cfg_idx_e    idx;
    logic [31:0] data;
  } job_t;

  typedef struct {
    status_e     st;
    logic [31:0] addr;
    logic        last;
  } word_t;

  localparam longint PAGE   = 64'd1 << PAGE_BITS;
  localparam int     LIMIT  = 2_000_000;
  localparam int     SETTLE = 40;

  logic        clk_i, rst_ni, start_i, busy_o;
  cmd_e        command;
  logic [31:0] page_addr_i, rand_value_i;
  logic [10:0] dump_count_i;
  logic        result_valid_o, last_o;
  logic [2:0]  status_o;
  logic [31:0] result_addr_o;
  logic        cfg_valid_i, cfg_ready_o;
  cfg_idx_e    cfg_index;
  logic [31:0] cfg_wdata_i;

  random_pick_page_allocator_unit u_top (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .command_i(command), .page_addr_i, .rand_value_i, .dump_count_i,
    .result_valid_o, .status_o, .result_addr_o, .last_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i(cfg_index), .cfg_wdata_i
  );

  job_t        job_q[$];
  word_t       result_q[$];
  logic [31:0] free_list[$];  // index 0 is the tail, back is the head
  logic [31:0] alloc_hist[$];
  logic [31:0] lim_start, lim_stop;

  int    fails, mism, words_seen, cycles;
  int    cmds_done, cfgs_done, gap, settle;
  bit    burst;
  bit    took_cmd, took_cfg;
  int    cnt_st[6];
  logic [31:0] gen_start, gen_stop;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Model of one accepted command: push the words it must produce.
  task automatic predict_words(job_t j);
    word_t w;
    int pos, idx;
    w.addr = '0;
    w.last = 1'b1;
    case (j.cmd)
      CMD_FREE: begin
        if (j.addr[PAGE_BITS-1:0] != '0 || j.addr < lim_start || j.addr >= lim_stop)
          w.st = ST_BAD_ADDR;
        else if (free_list.size() >= MAX_PAGES) w.st = ST_LIST_FULL;
        else begin
          free_list.push_back(j.addr);
          w.st = ST_OK;
        end
        result_q.push_back(w);
      end
      CMD_ALLOC: begin
        if (free_list.size() == 0) w.st = ST_EMPTY;
        else begin
          pos = j.rnd % free_list.size();
          idx = free_list.size() - 1 - pos;
          w.addr = free_list[idx];
          free_list.delete(idx);
          if (alloc_hist.size() >= LOG_DEPTH) w.st = ST_LOG_FULL;
          else begin
            alloc_hist.push_back(w.addr);
            w.st = ST_OK;
          end
        end
        result_q.push_back(w);
      end
      CMD_DUMP: begin
        if (j.n == 0 || j.n > alloc_hist.size() || j.n > MAX_DUMP) begin
          w.st = ST_BAD_DUMP;
          result_q.push_back(w);
        end else begin
          for (int k = 0; k < j.n; k++) begin
            w.st   = ST_OK;
            w.addr = alloc_hist[alloc_hist.size() - 1 - k];
            w.last = (k + 1 == j.n);
            result_q.push_back(w);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Sample accepts, config writes and result words.
  always @(posedge clk_i or negedge rst_ni) begin
    word_t w;
    if (!rst_ni) begin
      took_cmd <= 1'b0;
      took_cfg <= 1'b0;
      lim_start = '0;
      lim_stop  = MEM_STOP_RST;
    end else begin
      cycles++;
      if (cycles > LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("random_pick_page_allocator_unit test failed");
        $finish;
      end
      took_cmd <= start_i && !busy_o;
      took_cfg <= cfg_valid_i && cfg_ready_o;
      if (result_valid_o) begin
        words_seen++;
        if (result_q.size() == 0) begin
          fails++;
          if (mism++ < 10) $display("unexpected word: st=%0d addr=%h last=%b",
                                    status_o, result_addr_o, last_o);
        end else begin
          w = result_q.pop_front();
          if (status_o < 6) cnt_st[status_o]++;
          if (status_o !== w.st || result_addr_o !== w.addr || last_o !== w.last) begin
            fails++;
            if (mism++ < 10)
              $display("mismatch: exp st=%0d addr=%h last=%b got st=%0d addr=%h last=%b",
                       w.st, w.addr, w.last, status_o, result_addr_o, last_o);
          end
        end
      end
      if (start_i && !busy_o) begin
        predict_words(job_q[0]);
        cmds_done++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index == CFG_MEM_START) lim_start = cfg_wdata_i;
        else lim_stop = cfg_wdata_i;
        cfgs_done++;
      end
    end
  end

  // Driver: one job at a time from the head of job_q, changes on the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start_i) begin
        if (took_cmd) begin
          start_i <= 1'b0;
          void'(job_q.pop_front());
          if ($urandom_range(0, 31) == 0) burst = ~burst;
          gap <= burst ? 0 : $urandom_range(0, 14);
        end
      end else if (cfg_valid_i) begin
        if (took_cfg) begin
          cfg_valid_i <= 1'b0;
          void'(job_q.pop_front());
        end
      end else if (gap > 0) begin
        gap <= gap - 1;
      end else if (job_q.size() > 0) begin
        case (job_q[0].kind)
          JOB_CMD: begin
            start_i      <= 1'b1;
            command      <= job_q[0].cmd;
            page_addr_i  <= job_q[0].addr;
            rand_value_i <= job_q[0].rnd;
            dump_count_i <= job_q[0].n;
          end
          JOB_CFG: begin
            cfg_valid_i <= 1'b1;
            cfg_index   <= job_q[0].idx;
            cfg_wdata_i <= job_q[0].data;
          end
          default: begin
            // hold until the block is quiet, then let it settle
            if (result_q.size() == 0 && !busy_o) begin
              if (settle >= SETTLE) begin
                settle <= 0;
                void'(job_q.pop_front());
              end else settle <= settle + 1;
            end else settle <= 0;
          end
        endcase
      end
    end
  end

  function automatic job_t mk(cmd_e c, logic [31:0] a, logic [31:0] r, logic [10:0] n);
    job_t j;
    j.kind = JOB_CMD; j.cmd = c; j.addr = a; j.rnd = r; j.n = n;
    j.idx = CFG_MEM_START; j.data = '0;
    return j;
  endfunction

  function automatic logic [31:0] pick_addr();
    longint lo, hi;
    lo = (longint'(gen_start) + PAGE - 1) / PAGE;
    hi = (longint'(gen_stop) - 1) / PAGE;
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return {$urandom_range(0, 1) ? $urandom() : 32'h0} | 32'h1;
      2: return gen_stop & ~32'(PAGE - 1);
      3: return gen_start - 32'(PAGE);
      default: if (gen_stop == 0 || lo > hi) return $urandom() & ~32'(PAGE - 1);
               else return 32'(($urandom() % (hi - lo + 1) + lo) * PAGE);
    endcase
  endfunction

  task automatic add_limits(logic [31:0] s, logic [31:0] e);
    job_t j;
    j = mk(CMD_FREE, '0, '0, '0);
    j.kind = JOB_DRAIN; job_q.push_back(j);
    j.kind = JOB_CFG; j.idx = CFG_MEM_START; j.data = s; job_q.push_back(j);
    j.idx = CFG_MEM_STOP; j.data = e; job_q.push_back(j);
    gen_start = s; gen_stop = e;
  endtask

  task automatic add_random(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 42) job_q.push_back(mk(CMD_FREE, pick_addr(), $urandom(), 11'($urandom())));
      else if (r < 82)
        job_q.push_back(mk(CMD_ALLOC, $urandom(),
                           $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 40),
                           11'($urandom())));
      else if (r < 98)
        job_q.push_back(mk(CMD_DUMP, $urandom(), $urandom(),
                           $urandom_range(0, 7) == 0 ? 11'($urandom())
                                                     : 11'($urandom_range(1, 64))));
      else job_q.push_back(mk(CMD_NONE, $urandom(), $urandom(), 11'($urandom())));
    end
  endtask

  initial begin
    job_t d;
    rst_ni = 1'b0; start_i = 1'b0; cfg_valid_i = 1'b0;
    command = CMD_FREE; page_addr_i = '0; rand_value_i = '0; dump_count_i = '0;
    cfg_index = CFG_MEM_START; cfg_wdata_i = '0;
    gap = 0; settle = 0; burst = 0;
    gen_start = '0; gen_stop = MEM_STOP_RST;
    d = mk(CMD_FREE, '0, '0, '0);
    d.kind = JOB_DRAIN;

    // directed: reset limits, empty cases, edges of the address window
    job_q.push_back(mk(CMD_ALLOC, '0, 32'hFFFF_FFFF, '0));
    job_q.push_back(mk(CMD_DUMP, '0, '0, 11'd0));
    job_q.push_back(mk(CMD_DUMP, '0, '0, 11'd1));
    job_q.push_back(mk(CMD_FREE, 32'h0, '0, '0));
    job_q.push_back(mk(CMD_FREE, 32'h0DFF_F000, '0, '0));
    job_q.push_back(mk(CMD_FREE, 32'h0E00_0000, '0, '0));
    job_q.push_back(mk(CMD_FREE, 32'h0000_1001, '0, '0));
    job_q.push_back(mk(CMD_FREE, 32'hFFFF_FFFF, '0, '0));
    job_q.push_back(mk(CMD_FREE, 32'h0000_5000, '0, '0));
    job_q.push_back(mk(CMD_ALLOC, '0, 32'hFFFF_FFFF, '0));
    job_q.push_back(mk(CMD_ALLOC, '0, 32'h0, '0));
    job_q.push_back(mk(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'h7FF));
    job_q.push_back(mk(CMD_DUMP, '0, '0, 11'd1));
    job_q.push_back(mk(CMD_DUMP, '0, '0, 11'd2));
    job_q.push_back(mk(CMD_DUMP, '0, '0, 11'd3));
    job_q.push_back(mk(CMD_DUMP, '0, '0, 11'd65));
    job_q.push_back(mk(CMD_DUMP, '0, '0, 11'h7FF));
    job_q.push_back(d);
    job_q.push_back(mk(CMD_ALLOC, '0, 32'd7, '0));
    job_q.push_back(mk(CMD_ALLOC, '0, 32'd7, '0));
    add_random(130);

    add_limits(32'h0010_0000, 32'hFFFF_FFFF);
    add_random(130);
    add_limits(32'hFFFF_F000, 32'hFFFF_FFFF);
    add_random(40);
    add_limits(32'h0, 32'h0);
    add_random(30);
    add_limits(32'h0000_3000, 32'h0000_9000);
    add_random(60);

    // push a run of pages, then allocate as many times again
    add_limits(32'h0, 32'hFFFF_FFFF);
    for (int i = 0; i < 24; i++)
      job_q.push_back(mk(CMD_FREE, 32'(longint'(i + 1) * PAGE), '0, '0));
    for (int i = 0; i < 24; i++)
      job_q.push_back(mk(CMD_ALLOC, '0, (i % 8 == 0) ? $urandom() : $urandom_range(0, 3),
                         '0));
    job_q.push_back(mk(CMD_DUMP, '0, '0, 11'd64));
    job_q.push_back(mk(CMD_DUMP, '0, '0, 11'd1));
    job_q.push_back(d);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    wait (job_q.size() == 0 && result_q.size() == 0 && !busy_o);
    repeat (SETTLE) @(posedge clk_i);
    $display("%0d commands, %0d config writes, %0d result words over %0d cycles",
             cmds_done, cfgs_done, words_seen, cycles);
    $display("words by status ok/addr/empty/dump/list/log: %0d %0d %0d %0d %0d %0d",
             cnt_st[0], cnt_st[1], cnt_st[2], cnt_st[3], cnt_st[4], cnt_st[5]);
    if (fails == 0 && result_q.size() == 0) begin
      $display("random_pick_page_allocator_unit test passed");
    end else begin
      $display("%0d failures, %0d words left", fails, result_q.size());
      $display("random_pick_page_allocator_unit test failed");
    end
    $finish;
  end

endmodule
